### rtl/rotary_encoder_step_qualifier_assert.svh
// Assertion macros for the rotary encoder step qualifier.
`ifndef ROTARY_ENCODER_STEP_QUALIFIER_ASSERT_SVH
`define ROTARY_ENCODER_STEP_QUALIFIER_ASSERT_SVH
`ifndef SYNTH
`define RESE_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rese assertion failed");
`define RESE_NEVER(name, clk, rst_n, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("rese forbidden condition seen");
`else
`define RESE_ASSERT(name, clk, rst_n, prop)
`define RESE_NEVER(name, clk, rst_n, expr)
`endif
`endif

### rtl/rese_pkg.sv
// Shared types and constants of the rotary encoder step qualifier.
package rese_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned WaitW = 16;
  localparam int unsigned CountW = 4;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TICK_THRESHOLD   = 3'd0,
    CFG_CLOCK_PULSE_MS   = 3'd1,
    CFG_DATA_PULSE_MS    = 3'd2,
    CFG_SWITCH_PULSE_MS  = 3'd3,
    CFG_CLOCK_PAUSE_MS   = 3'd4,
    CFG_DATA_PAUSE_MS    = 3'd5,
    CFG_EVENT_HOLDOFF_MS = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_RIGHT = 2'd1,
    EV_LEFT  = 2'd2,
    EV_PRESS = 2'd3
  } event_e;

  typedef struct packed {
    logic [CountW-1:0] tick_threshold;
    logic [7:0]        clock_pulse_ms;
    logic [7:0]        data_pulse_ms;
    logic [7:0]        switch_pulse_ms;
    logic [WaitW-1:0]  clock_pause_ms;
    logic [WaitW-1:0]  data_pause_ms;
    logic [WaitW-1:0]  event_holdoff_ms;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    tick_threshold:   4'd3,
    clock_pulse_ms:   8'd1,
    data_pulse_ms:    8'd1,
    switch_pulse_ms:  8'd100,
    clock_pause_ms:   16'd4,
    data_pause_ms:    16'd4,
    event_holdoff_ms: 16'd100
  };

endpackage

### rtl/rese_cfg.sv
// Configuration register file of the step qualifier.
module rese_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rese_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rese_pkg::CfgDataW-1:0] cfg_data_i,
  output rese_pkg::cfg_t                cfg_o
);
  import rese_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_TICK_THRESHOLD:   cfg_d.tick_threshold   = cfg_data_i[CountW-1:0];
        CFG_CLOCK_PULSE_MS:   cfg_d.clock_pulse_ms   = cfg_data_i[7:0];
        CFG_DATA_PULSE_MS:    cfg_d.data_pulse_ms    = cfg_data_i[7:0];
        CFG_SWITCH_PULSE_MS:  cfg_d.switch_pulse_ms  = cfg_data_i[7:0];
        CFG_CLOCK_PAUSE_MS:   cfg_d.clock_pause_ms   = cfg_data_i[WaitW-1:0];
        CFG_DATA_PAUSE_MS:    cfg_d.data_pause_ms    = cfg_data_i[WaitW-1:0];
        CFG_EVENT_HOLDOFF_MS: cfg_d.event_holdoff_ms = cfg_data_i[WaitW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### rtl/rese_core.sv
// Debounce state and step decision for one pin sample.
module rese_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  rese_pkg::cfg_t             cfg_i,
  input  logic                       clock_level_i,
  input  logic                       data_level_i,
  input  logic                       switch_level_i,
  output rese_pkg::event_e           event_o,
  output logic [rese_pkg::WaitW-1:0] wait_o
);
  import rese_pkg::*;
  `include "rotary_encoder_step_qualifier_assert.svh"

  logic              clk_seen_q, clk_seen_d;
  logic              dat_seen_q, dat_seen_d;
  logic              sw_seen_q, sw_seen_d;
  logic [CountW-1:0] clk_cnt_q, clk_cnt_d;
  logic [CountW-1:0] dat_cnt_q, dat_cnt_d;

  always_comb begin
    clk_seen_d = clk_seen_q;
    dat_seen_d = dat_seen_q;
    sw_seen_d  = sw_seen_q;
    clk_cnt_d  = clk_cnt_q;
    dat_cnt_d  = dat_cnt_q;
    event_o    = EV_NONE;
    wait_o     = '0;
    unique case ({clock_level_i, data_level_i})
      2'b01: begin
        dat_cnt_d  = '0;
        dat_seen_d = 1'b0;
        if (!clk_seen_q) begin
          clk_seen_d = 1'b1;
          wait_o     = {8'd0, cfg_i.clock_pulse_ms};
        end else begin
          clk_seen_d = 1'b0;
          if (clk_cnt_q < cfg_i.tick_threshold) begin
            clk_cnt_d = clk_cnt_q + CountW'(1);
            wait_o    = cfg_i.clock_pause_ms;
          end else begin
            clk_cnt_d = '0;
            wait_o    = cfg_i.event_holdoff_ms;
            event_o   = EV_RIGHT;
          end
        end
      end
      2'b10: begin
        clk_cnt_d  = '0;
        clk_seen_d = 1'b0;
        if (!dat_seen_q) begin
          dat_seen_d = 1'b1;
          wait_o     = {8'd0, cfg_i.data_pulse_ms};
        end else begin
          dat_seen_d = 1'b0;
          if (dat_cnt_q < cfg_i.tick_threshold) begin
            dat_cnt_d = dat_cnt_q + CountW'(1);
            wait_o    = cfg_i.data_pause_ms;
          end else begin
            dat_cnt_d = '0;
            wait_o    = cfg_i.event_holdoff_ms;
            event_o   = EV_LEFT;
          end
        end
      end
      2'b11: begin
        clk_seen_d = 1'b0;
        dat_seen_d = 1'b0;
        clk_cnt_d  = '0;
        dat_cnt_d  = '0;
        if (!switch_level_i) begin
          if (!sw_seen_q) begin
            sw_seen_d = 1'b1;
            wait_o    = {8'd0, cfg_i.switch_pulse_ms};
          end else begin
            sw_seen_d = 1'b0;
            wait_o    = cfg_i.event_holdoff_ms;
            event_o   = EV_PRESS;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_seen_q <= 1'b0;
      dat_seen_q <= 1'b0;
      sw_seen_q  <= 1'b0;
      clk_cnt_q  <= '0;
      dat_cnt_q  <= '0;
    end else if (step_i) begin
      clk_seen_q <= clk_seen_d;
      dat_seen_q <= dat_seen_d;
      sw_seen_q  <= sw_seen_d;
      clk_cnt_q  <= clk_cnt_d;
      dat_cnt_q  <= dat_cnt_d;
    end
  end

  // only one direction can be mid-pulse
  `RESE_NEVER(a_one_dir_seen, clk_i, rst_ni, clk_seen_q && dat_seen_q)
  `RESE_ASSERT(a_right_clears, clk_i, rst_ni,
               (step_i && event_o == EV_RIGHT) |=> (clk_cnt_q == '0 && !clk_seen_q))
  `RESE_ASSERT(a_left_clears, clk_i, rst_ni,
               (step_i && event_o == EV_LEFT) |=> (dat_cnt_q == '0 && !dat_seen_q))
  `RESE_ASSERT(a_press_clears, clk_i, rst_ni,
               (step_i && event_o == EV_PRESS) |=> !sw_seen_q)

endmodule

### rtl/rotary_encoder_step_qualifier.sv
// Top level of the rotary encoder step qualifier.
//
//  channel | direction | handshake             | payload
//  in      | input     | in_valid_i/in_stall_o | clock_level_i data_level_i switch_level_i
//  out     | output    | out_valid_o/out_stall_i | event_code_o wait_ms_o
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i cfg_data_i
//
// One sample per cycle unless the output stalls; a sample waits in the input register,
// passes the step logic and its result is offered from the result register.
// Reset loads the register defaults and clears all debounce state; no clearing pass.
// A stalled result holds the input register, which then stalls the input side.
// The config port is always ready.
module rotary_encoder_step_qualifier (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          clock_level_i,
  input  logic                          data_level_i,
  input  logic                          switch_level_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    event_code_o,
  output logic [rese_pkg::WaitW-1:0]    wait_ms_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rese_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rese_pkg::CfgDataW-1:0] cfg_data_i
);
  import rese_pkg::*;

  cfg_t             cfg;
  logic             in_valid_q;
  logic             clk_lvl_q, dat_lvl_q, sw_lvl_q;
  logic             out_valid_q;
  event_e           event_q, event_d;
  logic [WaitW-1:0] wait_q, wait_d;
  logic             advance, accept;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  rese_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  rese_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (advance),
    .cfg_i          (cfg),
    .clock_level_i  (clk_lvl_q),
    .data_level_i   (dat_lvl_q),
    .switch_level_i (sw_lvl_q),
    .event_o        (event_d),
    .wait_o         (wait_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      clk_lvl_q <= clock_level_i;
      dat_lvl_q <= data_level_i;
      sw_lvl_q  <= switch_level_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      event_q <= event_d;
      wait_q  <= wait_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign event_code_o = event_q;
  assign wait_ms_o    = wait_q;

endmodule

### bench/tb_rotary_encoder_step_qualifier.sv
// Self-checking testbench for the rotary encoder step qualifier.
`timescale 1ns / 100ps

module tb_rotary_encoder_step_qualifier;
  import rese_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgIdxUnused = 3'd7;
  localparam int LongHoldCycles = 150;
  localparam int ReportLimit = 10;

  typedef struct {
    event_e           ev;
    logic [WaitW-1:0] wait_ms;
  } encoder_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic                clock_level_i = 1'b1;
  logic                data_level_i = 1'b1;
  logic                switch_level_i = 1'b1;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [1:0]          event_code_o;
  logic [WaitW-1:0]    wait_ms_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  // Shadow copy of the block's registers and debounce state
  cfg_t             shadow_cfg = CfgReset;
  logic             clock_seen = 1'b0;
  logic             data_seen = 1'b0;
  logic             press_seen = 1'b0;
  logic [CountW-1:0] clock_ticks = '0;
  logic [CountW-1:0] data_ticks = '0;

  encoder_result_t awaited_results[$];
  int failures = 0;
  int samples_sent = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int holdoff_requests = 0;
  int holdoffs_started = 0;
  int hold_left = 0;

  rotary_encoder_step_qualifier DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .clock_level_i  (clock_level_i),
    .data_level_i   (data_level_i),
    .switch_level_i (switch_level_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .event_code_o   (event_code_o),
    .wait_ms_o      (wait_ms_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  function automatic void count_pulse(inout logic seen, inout logic [CountW-1:0] ticks,
                                      input logic [WaitW-1:0] pulse_ms,
                                      input logic [WaitW-1:0] pause_ms,
                                      input event_e step_ev, output event_e ev,
                                      output logic [WaitW-1:0] wait_ms);
    ev = EV_NONE;
    if (!seen) begin
      seen = 1'b1;
      wait_ms = pulse_ms;
    end else begin
      seen = 1'b0;
      if (ticks < shadow_cfg.tick_threshold) begin
        ticks = ticks + 1'b1;
        wait_ms = pause_ms;
      end else begin
        ticks = '0;
        wait_ms = shadow_cfg.event_holdoff_ms;
        ev = step_ev;
      end
    end
  endfunction

  task automatic qualify_sample(input logic clk_lvl, input logic dat_lvl, input logic sw_lvl);
    encoder_result_t r;
    r.ev = EV_NONE;
    r.wait_ms = '0;
    if (!clk_lvl && dat_lvl) begin
      data_ticks = '0;
      data_seen = 1'b0;
      count_pulse(clock_seen, clock_ticks, {8'h00, shadow_cfg.clock_pulse_ms},
                  shadow_cfg.clock_pause_ms, EV_RIGHT, r.ev, r.wait_ms);
    end else if (clk_lvl && !dat_lvl) begin
      clock_ticks = '0;
      clock_seen = 1'b0;
      count_pulse(data_seen, data_ticks, {8'h00, shadow_cfg.data_pulse_ms},
                  shadow_cfg.data_pause_ms, EV_LEFT, r.ev, r.wait_ms);
    end else if (clk_lvl && dat_lvl) begin
      clock_seen = 1'b0;
      data_seen = 1'b0;
      clock_ticks = '0;
      data_ticks = '0;
      if (!sw_lvl) begin
        if (!press_seen) begin
          press_seen = 1'b1;
          r.wait_ms = {8'h00, shadow_cfg.switch_pulse_ms};
        end else begin
          press_seen = 1'b0;
          r.wait_ms = shadow_cfg.event_holdoff_ms;
          r.ev = EV_PRESS;
        end
      end
    end
    awaited_results.push_back(r);
  endtask

  // Called just after a rising edge; returns at the edge of the transfer.
  task automatic send_sample(input logic clk_lvl, input logic dat_lvl, input logic sw_lvl);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    clock_level_i <= clk_lvl;
    data_level_i <= dat_lvl;
    switch_level_i <= sw_lvl;
    do @(negedge clk_i); while (in_stall_o);
    @(posedge clk_i);
    qualify_sample(clk_lvl, dat_lvl, sw_lvl);
    samples_sent++;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    case (cfg_idx_e'(idx))
      CFG_TICK_THRESHOLD:   shadow_cfg.tick_threshold = value[CountW-1:0];
      CFG_CLOCK_PULSE_MS:   shadow_cfg.clock_pulse_ms = value[7:0];
      CFG_DATA_PULSE_MS:    shadow_cfg.data_pulse_ms = value[7:0];
      CFG_SWITCH_PULSE_MS:  shadow_cfg.switch_pulse_ms = value[7:0];
      CFG_CLOCK_PAUSE_MS:   shadow_cfg.clock_pause_ms = value;
      CFG_DATA_PAUSE_MS:    shadow_cfg.data_pause_ms = value;
      CFG_EVENT_HOLDOFF_MS: shadow_cfg.event_holdoff_ms = value;
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_settings(input cfg_t s);
    write_reg(CFG_TICK_THRESHOLD, {12'($urandom), s.tick_threshold});
    write_reg(CFG_CLOCK_PULSE_MS, {8'($urandom), s.clock_pulse_ms});
    write_reg(CFG_DATA_PULSE_MS, {8'($urandom), s.data_pulse_ms});
    write_reg(CFG_SWITCH_PULSE_MS, {8'($urandom), s.switch_pulse_ms});
    write_reg(CFG_CLOCK_PAUSE_MS, s.clock_pause_ms);
    write_reg(CFG_DATA_PAUSE_MS, s.data_pause_ms);
    write_reg(CFG_EVENT_HOLDOFF_MS, s.event_holdoff_ms);
  endtask

  function automatic cfg_t random_settings();
    cfg_t s;
    s.tick_threshold = ($urandom_range(3) == 0) ? 4'($urandom) : 4'($urandom_range(2));
    s.clock_pulse_ms = 8'($urandom);
    s.data_pulse_ms = 8'($urandom);
    s.switch_pulse_ms = 8'($urandom);
    s.clock_pause_ms = 16'($urandom);
    s.data_pause_ms = 16'($urandom);
    s.event_holdoff_ms = 16'($urandom);
    return s;
  endfunction

  // Lets every outstanding result drain before the registers are touched.
  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic note_failure(input string msg);
    failures++;
    if (failures <= ReportLimit) $display("ERROR %0t: %s", $realtime, msg);
  endtask

  task automatic test_levels_and_press();
    send_sample(1'b0, 1'b0, 1'b0);
    send_sample(1'b0, 1'b0, 1'b1);
    send_sample(1'b1, 1'b1, 1'b1);
    send_sample(1'b1, 1'b1, 1'b0);
    send_sample(1'b0, 1'b1, 1'b0);  // turning leaves the press flag alone
    send_sample(1'b1, 1'b1, 1'b1);  // released keeps it
    send_sample(1'b1, 1'b1, 1'b0);
  endtask

  task automatic test_default_steps();
    repeat (8) send_sample(1'b0, 1'b1, 1'($urandom));
  endtask

  task automatic test_threshold_edges();
    settle_block();
    write_reg(CFG_TICK_THRESHOLD, 16'd0);
    send_sample(1'b1, 1'b0, 1'b1);
    send_sample(1'b1, 1'b0, 1'b0);
    settle_block();
    write_reg(CFG_TICK_THRESHOLD, 16'd15);
    repeat (4) send_sample(1'b0, 1'b1, 1'b1);
    settle_block();
    write_reg(CFG_TICK_THRESHOLD, 16'd1);  // below the running count
    repeat (2) send_sample(1'b0, 1'b1, 1'b0);
  endtask

  task automatic test_unknown_index();
    settle_block();
    write_reg(CfgIdxUnused, 16'($urandom));
    send_sample(1'b1, 1'b0, 1'b0);
    send_sample(1'b1, 1'b0, 1'b1);
    send_sample(1'b1, 1'b1, 1'b0);
    send_sample(1'b1, 1'b1, 1'b0);
  endtask

  task automatic send_random_burst();
    int kind;
    int len;
    logic dir;
    kind = $urandom_range(99);
    if (kind < 45) begin
      dir = 1'($urandom);
      len = $urandom_range(1, 2 * (shadow_cfg.tick_threshold + 1) + 3);
      repeat (len) begin
        if ($urandom_range(7) == 0) send_sample(1'b0, 1'b0, 1'($urandom));
        else send_sample(dir, !dir, 1'($urandom));
      end
    end else if (kind < 75) begin
      repeat ($urandom_range(1, 4)) send_sample(1'b1, 1'b1, $urandom_range(3) != 0 ? 1'b0 : 1'b1);
    end else begin
      repeat ($urandom_range(1, 6)) send_sample(1'($urandom), 1'($urandom), 1'($urandom));
    end
  endtask

  task automatic test_random_traffic(input int sender_idle, input int receiver_stall,
                                     input cfg_t s, input int count);
    int stop_at;
    settle_block();
    load_settings(s);
    send_idle_pct = sender_idle;
    stall_pct = receiver_stall;
    stop_at = samples_sent + count;
    while (samples_sent < stop_at) send_random_burst();
  endtask

  task automatic test_backpressure();
    settle_block();
    send_idle_pct = 0;
    stall_pct = 0;
    @(negedge clk_i);
    holdoff_requests++;
    @(posedge clk_i);
    repeat (60) send_sample(1'b0, 1'b1, 1'($urandom));
  endtask

  always @(posedge clk_i) begin
    if (holdoffs_started != holdoff_requests) begin
      holdoffs_started <= holdoff_requests;
      hold_left <= LongHoldCycles;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Result transfers are sampled mid-cycle, where outputs are settled.
  always @(negedge clk_i) begin
    encoder_result_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_results.size() == 0) begin
        note_failure($sformatf("unexpected result event %0d wait %0d", event_code_o,
                               wait_ms_o));
      end else begin
        exp_r = awaited_results.pop_front();
        if (event_code_o !== exp_r.ev || wait_ms_o !== exp_r.wait_ms)
          note_failure($sformatf("expected event %0d wait %0d, got event %0d wait %0d",
                                 exp_r.ev, exp_r.wait_ms, event_code_o, wait_ms_o));
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_levels_and_press();
    test_default_steps();
    test_threshold_edges();
    test_unknown_index();
    test_random_traffic(0, 0, '1, 440);
    test_random_traffic(50, 0, '0, 440);
    test_backpressure();
    test_random_traffic(0, 50, random_settings(), 440);
    test_random_traffic(15, 15, random_settings(), 440);
    settle_block();
    repeat (8) @(posedge clk_i);
    if (failures == 0) begin
      $display("tb_rotary_encoder_step_qualifier passed");
    end else begin
      $display("tb_rotary_encoder_step_qualifier failed");
    end
    $finish;
  end

  initial begin
    #(12 * 400_000);
    $display("tb_rotary_encoder_step_qualifier failed");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/rese_pkg.sv
rtl/rese_cfg.sv
rtl/rese_core.sv
rtl/rotary_encoder_step_qualifier.sv
bench/tb_rotary_encoder_step_qualifier.sv
